// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("port check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

// File: sv/eccm_pkg.sv
// ----------------------------------------------------------------------------
// eccm_pkg
// Action codes and fixed field widths of the edge coverage counter map.
// ----------------------------------------------------------------------------
package eccm_pkg;

  localparam int ACT_W   = 2;
  localparam int ADDR_W  = 64;
  localparam int IDX_W   = 16;
  localparam int CNT_W   = 8;
  localparam int SUM_W   = 24;

  typedef logic [ACT_W-1:0] action_t;
  typedef logic [CNT_W-1:0] count_t;
  typedef logic [SUM_W-1:0] sum_t;

  localparam action_t ACT_RECORD = 2'd0;
  localparam action_t ACT_READ   = 2'd1;
  localparam action_t ACT_CLEAR  = 2'd2;

  localparam count_t COUNT_MAX = 8'd255;

endpackage

// File: sv/eccm_map.sv
// ----------------------------------------------------------------------------
// eccm_map
// Counter map memory: one registered read port, one write port, and a
// zeroing sweep over every entry after reset.
// ----------------------------------------------------------------------------
module eccm_map #(
  parameter int MAP_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [MAP_BITS-1:0]    rd_addr,
  output eccm_pkg::count_t       rd_data,
  input  logic                   wr_en,
  input  logic [MAP_BITS-1:0]    wr_addr,
  input  eccm_pkg::count_t       wr_data,
  output logic                   clearing
);
  import eccm_pkg::*;

  localparam int DEPTH = 1 << MAP_BITS;

  count_t mem [DEPTH];

  logic                clearing_r;
  logic [MAP_BITS-1:0] clr_addr_r;
  count_t              rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (&clr_addr_r) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clearing_r;

endmodule

// File: sv/edge_coverage_counter_map.sv
// ----------------------------------------------------------------------------
// edge_coverage_counter_map
// Hashed branch edge coverage map of saturating 8-bit counters with a
// running total of all counters.
// ----------------------------------------------------------------------------
//  channel  | handshake          | beat fields
//  ---------+--------------------+---------------------------------------------
//  input    | start / busy       | in_action, in_branch_address, in_entry_index
//  result   | out_valid (strobe) | out_index_used, out_counter_value,
//           |                    | out_running_total
//
//  Each beat: memory read at accept, modify and write back in the next
//  cycle; the result strobe follows in the cycle after that.
//  busy is high for the cycle after accept, so a new beat can be taken in the
//  cycle the previous result is shown.
//  After reset the map is zeroed one entry a cycle: busy holds high until
//  every entry is zeroed. The result side cannot stall.
// ----------------------------------------------------------------------------
module edge_coverage_counter_map #(
  parameter int MAP_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  eccm_pkg::action_t                   in_action,
  input  logic [eccm_pkg::ADDR_W-1:0]         in_branch_address,
  input  logic [eccm_pkg::IDX_W-1:0]          in_entry_index,
  output logic                                out_valid,
  output logic [eccm_pkg::IDX_W-1:0]          out_index_used,
  output eccm_pkg::count_t                    out_counter_value,
  output eccm_pkg::sum_t                      out_running_total
);
  import eccm_pkg::*;

  localparam int EXT_W = 32;

  logic                clearing;
  logic                accept;
  logic [ADDR_W-1:0]   fold;
  logic [EXT_W-1:0]    entry_ext;
  logic [MAP_BITS-1:0] entry_idx;
  logic [MAP_BITS-1:0] hash_idx;
  logic [MAP_BITS-1:0] sel_idx;

  logic                exec_r;
  action_t             act_r;
  logic [MAP_BITS-1:0] idx_r;
  logic [MAP_BITS-1:0] prev_r;
  sum_t                sum_r;
  sum_t                sum_nxt;

  count_t              rd_data;
  count_t              new_cnt;
  logic                wr_en;
  logic [EXT_W-1:0]    idx_ext;

  logic                out_valid_r;
  logic [IDX_W-1:0]    out_idx_r;
  count_t              out_cnt_r;

  assign accept    = start && !busy;
  assign busy      = clearing || exec_r;

  assign fold      = (in_branch_address >> 4) ^ (in_branch_address >> 12);
  assign hash_idx  = fold[MAP_BITS-1:0] ^ prev_r;
  assign entry_ext = {{(EXT_W-IDX_W){1'b0}}, in_entry_index};
  assign entry_idx = entry_ext[MAP_BITS-1:0];
  assign sel_idx   = (in_action == ACT_RECORD) ? hash_idx : entry_idx;

  eccm_map #(
    .MAP_BITS (MAP_BITS)
  ) u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (sel_idx),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (idx_r),
    .wr_data  (new_cnt),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exec_r <= 1'b0;
      prev_r <= '0;
    end else begin
      exec_r <= accept;
      if (accept && in_action == ACT_RECORD) begin
        prev_r <= fold[MAP_BITS:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_action;
      idx_r <= sel_idx;
    end
  end

  always_comb begin
    new_cnt = rd_data;
    sum_nxt = sum_r;
    wr_en   = 1'b0;
    if (exec_r) begin
      case (act_r)
        ACT_RECORD: begin
          wr_en = 1'b1;
          if (rd_data != COUNT_MAX) begin
            new_cnt = rd_data + 8'd1;
            sum_nxt = sum_r + 24'd1;
          end
        end
        ACT_CLEAR: begin
          wr_en   = 1'b1;
          new_cnt = '0;
          sum_nxt = sum_r - {{(SUM_W-CNT_W){1'b0}}, rd_data};
        end
        default: begin
          new_cnt = rd_data;
        end
      endcase
    end
  end

  assign idx_ext = {{(EXT_W-MAP_BITS){1'b0}}, idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      out_valid_r <= exec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_r) begin
      out_idx_r <= idx_ext[IDX_W-1:0];
      out_cnt_r <= new_cnt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_index_used    = out_idx_r;
  assign out_counter_value = out_cnt_r;
  assign out_running_total = sum_r;

endmodule

// File: sv/eccm_checker.sv
// ----------------------------------------------------------------------------
// eccm_checker
// Port-level timing and value checks for the edge coverage counter map.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eccm_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  eccm_pkg::action_t             in_action,
  input  logic                          out_valid,
  input  eccm_pkg::count_t              out_counter_value
);
  import eccm_pkg::*;

  `ASSERT_IMPL(a_result_follows_accept, out_valid, $past(start && !busy, 2))
  `ASSERT_NEXT(a_strobe_one_cycle, out_valid, !out_valid)
  `ASSERT_IMPL(a_clear_gives_zero, out_valid && $past(in_action == ACT_CLEAR, 2),
               out_counter_value == '0)
  `ASSERT_IMPL(a_record_nonzero, out_valid && $past(in_action == ACT_RECORD, 2),
               out_counter_value != '0)

endmodule

bind edge_coverage_counter_map eccm_checker u_eccm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_action         (in_action),
  .out_valid         (out_valid),
  .out_counter_value (out_counter_value)
);
